### src/fbpc_pkg.sv
// Shared constants, types and helpers for the framebuffer to page converter.
`timescale 1ns / 1ps

package fbpc_pkg;

  // Frame geometry.
  localparam int ROW_BYTES  = 16;
  localparam int PAGE_COUNT = 16;
  localparam int COL_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PAGE_W     = 4;
  localparam int ROW_W      = 3;
  localparam int STORE_ROWS = 7;

  // Panel command words.
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;

  // Output sequence positions within one tile job.
  localparam logic [3:0] STEP_PAGE     = 4'd0;
  localparam logic [3:0] STEP_COL_HIGH = 4'd1;
  localparam logic [3:0] STEP_COL_LOW  = 4'd2;
  localparam logic [3:0] STEP_DATA0    = 4'd3;
  localparam logic [3:0] STEP_LAST     = 4'd10;

  // One tile job: stored rows 0..6 of a column byte, the row 7 byte and its strip.
  typedef struct packed {
    logic [STORE_ROWS-1:0][7:0] rows;
    logic [7:0]                 px;
    logic [PAGE_W-1:0]          page;
    logic                       first;
  } job_t;

  // Column k of a tile, MSB of each row byte is column 0; bit r is row r.
  function automatic logic [7:0] tile_column(job_t job, logic [2:0] k);
    logic [7:0] col;
    logic [2:0] bit_sel;
    bit_sel = 3'd7 - k;
    for (int r = 0; r < STORE_ROWS; r++) begin
      col[r] = job.rows[r][bit_sel];
    end
    col[7] = job.px[bit_sel];
    return col;
  endfunction

endpackage

### src/framebuffer_to_page_converter.sv
// Top level of the framebuffer to page converter.
// Rows 0..6 words are taken one per cycle unless a full queue holds the job stage,
// and give no output. A row 7 word passes the job stage, the two-job queue that
// absorbs bursts and the back end's single output register; then its eight data
// words (eleven with the three strip commands) go out one per cycle unless stalled.
// Synchronous active-high reset clears the frame position, queue and output valid.
`timescale 1ns / 1ps

module framebuffer_to_page_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] pixel_byte
  input  logic       s_axis_tuser,  // [0] start_of_frame
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic       m_axis_tuser,  // [0] is_data
  output logic       m_axis_tlast
);

  logic           front_valid;
  fbpc_pkg::job_t front_job;
  logic           queue_full;
  logic           head_valid;
  fbpc_pkg::job_t head_job;
  logic           head_pop;

  fbpc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .pixel_byte     (s_axis_tdata),
    .start_of_frame (s_axis_tuser),
    .job_valid      (front_valid),
    .job            (front_job),
    .job_full       (queue_full)
  );

  fbpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_job   (front_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (head_pop)
  );

  fbpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (head_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .is_data   (m_axis_tuser),
    .last      (m_axis_tlast)
  );

endmodule

### src/fbpc_front.sv
// Front end: frame position counters, strip row store and tile job issue.
`timescale 1ns / 1ps

module fbpc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    pixel_byte,
  input  logic          start_of_frame,
  output logic          job_valid,
  output fbpc_pkg::job_t job,
  input  logic          job_full
);

  logic [fbpc_pkg::ROW_W-1:0]  row_in_strip, row_in_strip_next, cur_row;
  logic [fbpc_pkg::COL_W-1:0]  column_byte, column_byte_next, cur_col;
  logic [fbpc_pkg::PAGE_W-1:0] page_index, page_index_next, cur_page;
  logic                        accept;
  logic                        is_tile_row;
  logic                        push;

  // Rows 0..6 of the strip, one entry per column byte.
  logic [fbpc_pkg::STORE_ROWS-1:0][7:0] strip_rows [fbpc_pkg::ROW_BYTES];

  // A start flag takes the word as the first one of a new frame.
  assign cur_row  = start_of_frame ? '0 : row_in_strip;
  assign cur_col  = start_of_frame ? '0 : column_byte;
  assign cur_page = start_of_frame ? '0 : page_index;

  assign is_tile_row = (cur_row == fbpc_pkg::ROW_W'(fbpc_pkg::STORE_ROWS));
  assign push        = job_valid && !job_full;
  assign in_ready    = !job_valid || !job_full;
  assign accept      = in_valid && in_ready;

  // Position advance: column wraps into the row, row 7 into the page.
  always_comb begin
    row_in_strip_next = cur_row;
    column_byte_next  = cur_col + 1'b1;
    page_index_next   = cur_page;
    if (cur_col == fbpc_pkg::COL_W'(fbpc_pkg::ROW_BYTES - 1)) begin
      column_byte_next = '0;
      if (is_tile_row) begin
        row_in_strip_next = '0;
        if (cur_page == fbpc_pkg::PAGE_W'(fbpc_pkg::PAGE_COUNT - 1)) begin
          page_index_next = '0;
        end else begin
          page_index_next = cur_page + 1'b1;
        end
      end else begin
        row_in_strip_next = cur_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_strip <= '0;
      column_byte  <= '0;
      page_index   <= '0;
    end else if (accept) begin
      row_in_strip <= row_in_strip_next;
      column_byte  <= column_byte_next;
      page_index   <= page_index_next;
    end
  end

  // Store writes for rows 0..6; row 7 reads the whole column entry.
  always_ff @(posedge clk) begin
    if (accept && !is_tile_row) begin
      strip_rows[cur_col][cur_row] <= pixel_byte;
    end
    if (accept && is_tile_row) begin
      job.rows  <= strip_rows[cur_col];
      job.px    <= pixel_byte;
      job.page  <= cur_page;
      job.first <= (cur_col == '0);
    end
  end

  // Job stage holds until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && is_tile_row) begin
      job_valid <= 1'b1;
    end else if (push) begin
      job_valid <= 1'b0;
    end
  end

endmodule

### src/fbpc_queue.sv
// Two-entry queue of tile jobs between the front and back ends.
`timescale 1ns / 1ps

module fbpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  fbpc_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output fbpc_pkg::job_t head_job,
  input  logic           pop
);

  fbpc_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/fbpc_back.sv
// Back end: command and transposed column byte sequencer with output register.
`timescale 1ns / 1ps

module fbpc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  fbpc_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           is_data,
  output logic           last
);

  logic [3:0] idx;
  logic [3:0] step;
  logic [2:0] col_k;
  logic       load;
  logic       step_last;
  logic [7:0] byte_next;
  logic       data_next;

  // Later tiles of a strip skip the three commands.
  assign step      = job.first ? idx : idx + fbpc_pkg::STEP_DATA0;
  assign col_k     = 3'(step - fbpc_pkg::STEP_DATA0);
  assign step_last = (step == fbpc_pkg::STEP_LAST);
  assign load      = job_valid && (!out_valid || out_ready);
  assign job_pop   = load && step_last;

  // Word selection for the current step.
  always_comb begin
    case (step)
      fbpc_pkg::STEP_PAGE: begin
        byte_next = fbpc_pkg::CMD_PAGE_BASE | {4'h0, job.page};
        data_next = 1'b0;
      end
      fbpc_pkg::STEP_COL_HIGH: begin
        byte_next = fbpc_pkg::CMD_COL_HIGH;
        data_next = 1'b0;
      end
      fbpc_pkg::STEP_COL_LOW: begin
        byte_next = fbpc_pkg::CMD_COL_LOW;
        data_next = 1'b0;
      end
      default: begin
        byte_next = fbpc_pkg::tile_column(job, col_k);
        data_next = 1'b1;
      end
    endcase
  end

  // Step counter within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= step_last ? '0 : idx + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      is_data  <= data_next;
      last     <= step_last;
    end
  end

endmodule

### src/fbpc_checker.sv
// Port-level checks for the framebuffer to page converter, bound to the top level.
`timescale 1ns / 1ps

module fbpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Command words never close a tile.
  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast)
    else $error("command word marked last");

  // Only page address and column zero commands are issued.
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[7:4] == 4'hB || m_axis_tdata == 8'h10 || m_axis_tdata == 8'h00))
    else $error("unexpected command word");

endmodule

bind framebuffer_to_page_converter fbpc_checker u_fbpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
